// File: src/mcas_pkg.sv
// ----------------------------------------------------------------------------
// mcas_pkg
// Shared constants, controller states, datapath commands and status for the
// least-cost assignment search core.
// ----------------------------------------------------------------------------
package mcas_pkg;

	localparam int MAX_SIZE  = 8;
	localparam int COST_BITS = 16;
	localparam int SUM_W     = 19;
	localparam int SIZE_W    = 4;
	localparam int IDX_W     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int CNT_W     = $clog2(MAX_SIZE + 1);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int PADDR_W   = 3;

	localparam logic [PADDR_W-3:0] REG_SIZE_IN_USE = '0;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DIAG_RD,
		ST_DIAG_ACC,
		ST_MIN_RD,
		ST_MIN_ACC,
		ST_TRY,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_DIAG_RD,
		OP_DIAG_ACC,
		OP_MIN_RD,
		OP_MIN_ACC,
		OP_TRY,
		OP_EVAL,
		OP_HOLD
	} op_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
		logic out_valid;
	} cmd_t;

	typedef struct packed {
		logic last_cost;
		logic diag_last;
		logic min_last;
		logic try_done;
		logic try_read;
	} status_t;

endpackage

// File: src/mcas_if.sv
// ----------------------------------------------------------------------------
// mcas_if
// Valid/ready channels for incoming costs and outgoing results.
// ----------------------------------------------------------------------------
interface mcas_cost_if import mcas_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [COST_BITS-1:0] cost;

	modport source (output valid, output cost, input ready);
	modport sink   (input valid, input cost, output ready);
endinterface

interface mcas_result_if import mcas_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] min_cost;

	modport source (output valid, output min_cost, input ready);
	modport sink   (input valid, input min_cost, output ready);
endinterface

// File: src/mcas_ctrl.sv
// ----------------------------------------------------------------------------
// mcas_ctrl
// Sequencer for load, bound set-up, depth-first search and result hand-off.
// ----------------------------------------------------------------------------
module mcas_ctrl import mcas_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic    out_fire,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:     if (in_fire && status.last_cost) state_d = ST_DIAG_RD;
			ST_DIAG_RD:  state_d = ST_DIAG_ACC;
			ST_DIAG_ACC: state_d = status.diag_last ? ST_MIN_RD : ST_DIAG_RD;
			ST_MIN_RD:   state_d = ST_MIN_ACC;
			ST_MIN_ACC:  state_d = status.min_last ? ST_TRY : ST_MIN_RD;
			ST_TRY: begin
				priority if (status.try_done) state_d = ST_DONE;
				else if (status.try_read)     state_d = ST_EVAL;
				else                          state_d = ST_TRY;
			end
			ST_EVAL:     state_d = ST_TRY;
			ST_DONE:     if (out_fire) state_d = ST_LOAD;
			default:     state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd.in_ready  = 1'b0;
		cmd.out_valid = 1'b0;
		cmd.op        = OP_HOLD;
		unique case (state_q)
			ST_LOAD: begin
				cmd.op       = OP_LOAD;
				cmd.in_ready = 1'b1;
			end
			ST_DIAG_RD:  cmd.op = OP_DIAG_RD;
			ST_DIAG_ACC: cmd.op = OP_DIAG_ACC;
			ST_MIN_RD:   cmd.op = OP_MIN_RD;
			ST_MIN_ACC:  cmd.op = OP_MIN_ACC;
			ST_TRY:      cmd.op = OP_TRY;
			ST_EVAL:     cmd.op = OP_EVAL;
			ST_DONE:     cmd.out_valid = 1'b1;
			default:     cmd.op = OP_HOLD;
		endcase
	end

endmodule

// File: src/mcas_dp.sv
// ----------------------------------------------------------------------------
// mcas_dp
// Cost memory, row-minimum suffix bounds, search stack and running sums.
// ----------------------------------------------------------------------------
module mcas_dp import mcas_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic                 in_fire,
	input  logic [COST_BITS-1:0] cost,
	input  logic                 cfg_wr,
	input  logic [CNT_W-1:0]     n,
	output status_t              status,
	output logic [SUM_W-1:0]     min_cost
);

	logic [COST_BITS-1:0] mem [2**ADDR_W];
	logic [COST_BITS-1:0] rdata_q;
	logic [ADDR_W-1:0]    rd_addr;

	logic [IDX_W-1:0]     ld_row_q, ld_col_q;
	logic [IDX_W-1:0]     r_q, c_q;
	logic [COST_BITS-1:0] m_q;
	logic [SUM_W-1:0]     acc_q, best_q, sum_q;
	logic [IDX_W-1:0]     row_q;
	logic [CNT_W-1:0]     col_q;
	logic [MAX_SIZE-1:0]  used_q;

	logic [SUM_W-1:0]     sb_q [MAX_SIZE];
	logic [IDX_W-1:0]     ch_q [MAX_SIZE];
	logic [COST_BITS-1:0] cs_q [MAX_SIZE];

	logic [CNT_W-1:0]     n_last;
	logic [IDX_W-1:0]     col_idx, row_up, row_dn;
	logic                 ld_last, col_end, last_row, min_row_end;
	logic [COST_BITS-1:0] m_new;
	logic [SUM_W-1:0]     acc_new, s_new, bound;

	assign n_last      = n - CNT_W'(1);
	assign col_idx     = col_q[IDX_W-1:0];
	assign row_up      = row_q + IDX_W'(1);
	assign row_dn      = row_q - IDX_W'(1);
	assign ld_last     = (CNT_W'(ld_row_q) == n_last) && (CNT_W'(ld_col_q) == n_last);
	assign col_end     = (col_q == n);
	assign last_row    = (CNT_W'(row_q) == n_last);
	assign min_row_end = (CNT_W'(c_q) == n_last);
	assign m_new       = ((c_q == '0) || (rdata_q < m_q)) ? rdata_q : m_q;
	assign acc_new     = acc_q + SUM_W'(m_new);
	assign s_new       = sum_q + SUM_W'(rdata_q);
	assign bound       = s_new + sb_q[row_up];

	assign status.last_cost = ld_last;
	assign status.diag_last = (CNT_W'(r_q) == n_last);
	assign status.min_last  = min_row_end && (r_q == '0);
	assign status.try_done  = col_end && (row_q == '0);
	assign status.try_read  = !col_end && !used_q[col_idx];
	assign min_cost         = best_q;

	always_comb begin
		unique case (cmd.op)
			OP_DIAG_RD: rd_addr = {r_q, r_q};
			OP_MIN_RD:  rd_addr = {r_q, c_q};
			OP_TRY:     rd_addr = {row_q, col_idx};
			default:    rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && in_fire) begin
			mem[{ld_row_q, ld_col_q}] <= cost;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_row_q <= '0;
			ld_col_q <= '0;
			r_q      <= '0;
			c_q      <= '0;
			m_q      <= '0;
			acc_q    <= '0;
			best_q   <= '0;
			sum_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			used_q   <= '0;
		end else if (cfg_wr) begin
			ld_row_q <= '0;
			ld_col_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					if (in_fire) begin
						priority if (ld_last) begin
							ld_row_q <= '0;
							ld_col_q <= '0;
							r_q      <= '0;
							best_q   <= '0;
						end else if (CNT_W'(ld_col_q) == n_last) begin
							ld_col_q <= '0;
							ld_row_q <= ld_row_q + IDX_W'(1);
						end else begin
							ld_col_q <= ld_col_q + IDX_W'(1);
						end
					end
				end
				OP_DIAG_ACC: begin
					best_q <= best_q + SUM_W'(rdata_q);
					if (status.diag_last) begin
						r_q   <= n_last[IDX_W-1:0];
						c_q   <= '0;
						acc_q <= '0;
					end else begin
						r_q <= r_q + IDX_W'(1);
					end
				end
				OP_MIN_ACC: begin
					m_q <= m_new;
					if (min_row_end) begin
						acc_q <= acc_new;
						c_q   <= '0;
						if (r_q == '0) begin
							row_q  <= '0;
							col_q  <= '0;
							used_q <= '0;
							sum_q  <= '0;
						end else begin
							r_q <= r_q - IDX_W'(1);
						end
					end else begin
						c_q <= c_q + IDX_W'(1);
					end
				end
				OP_TRY: begin
					if (col_end) begin
						if (row_q != '0) begin
							used_q[ch_q[row_dn]] <= 1'b0;
							sum_q <= sum_q - SUM_W'(cs_q[row_dn]);
							row_q <= row_dn;
							col_q <= CNT_W'(ch_q[row_dn]) + CNT_W'(1);
						end
					end else if (used_q[col_idx]) begin
						col_q <= col_q + CNT_W'(1);
					end
				end
				OP_EVAL: begin
					priority if (last_row) begin
						if (s_new < best_q) best_q <= s_new;
						col_q <= col_q + CNT_W'(1);
					end else if (bound < best_q) begin
						used_q[col_idx] <= 1'b1;
						sum_q <= s_new;
						row_q <= row_up;
						col_q <= '0;
					end else begin
						col_q <= col_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_MIN_ACC && min_row_end) begin
			sb_q[r_q] <= acc_new;
		end
		if (cmd.op == OP_EVAL && !last_row && bound < best_q) begin
			ch_q[row_q] <= col_idx;
			cs_q[row_q] <= rdata_q;
		end
	end

	a_used_matches_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_TRY |-> $countones(used_q) == row_q)
		else $error("used columns disagree with search depth");

	a_eval_free_column: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EVAL |-> !col_end && !used_q[col_idx])
		else $error("evaluating a used or out-of-range column");

	a_eval_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EVAL |-> $past(cmd.op) == OP_TRY && $stable(col_q))
		else $error("evaluation without matching read");

endmodule

// File: src/min_cost_assignment_search_core.sv
// ----------------------------------------------------------------------------
// min_cost_assignment_search_core
// Least-cost assignment of an n-by-n cost matrix by branch and bound.
// ----------------------------------------------------------------------------
// Costs are taken one per cycle while in the load state; the matrix load takes n*n costs.
// After the final cost the diagonal bound is summed, then the row-minimum suffix bounds,
// then the depth-first search steps through the columns and reads each free column's cost.
// The result is held until taken, then the next load begins.
// Reset clears the load position and search control and sets size_in_use to 8.
module min_cost_assignment_search_core import mcas_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	mcas_cost_if.sink          cost_ch,
	mcas_result_if.source      result_ch
);

	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  n;
	logic              cfg_wr, in_fire, out_fire;
	cmd_t              cmd;
	status_t           status;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_SIZE_IN_USE);
	assign prdata   = (paddr[PADDR_W-1:2] == REG_SIZE_IN_USE) ? 32'(size_q) : '0;
	assign in_fire  = cost_ch.valid && cost_ch.ready;
	assign out_fire = result_ch.valid && result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(8);
		end else if (cfg_wr) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		priority if (size_q == '0)                n = CNT_W'(1);
		else if (32'(size_q) > MAX_SIZE)          n = CNT_W'(MAX_SIZE);
		else                                      n = CNT_W'(size_q);
	end

	assign cost_ch.ready   = cmd.in_ready;
	assign result_ch.valid = cmd.out_valid;

	mcas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_fire (out_fire),
		.status   (status),
		.cmd      (cmd)
	);

	mcas_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_fire  (in_fire),
		.cost     (cost_ch.cost),
		.cfg_wr   (cfg_wr),
		.n        (n),
		.status   (status),
		.min_cost (result_ch.min_cost)
	);

endmodule
